>>> hdl/ptun_pkg.sv
`timescale 1ns / 1ps
// Shared constants, register codes and control types for the periodic triangle unit normal.
// No dependencies; every other file of the block imports this package.
package ptun_pkg;

  localparam int COORD_WIDTH_DEF   = 32;
  localparam int OUT_FRAC_BITS_DEF = 30;
  localparam int BOX_WIDTH         = 31;
  localparam int CFG_IDX_WIDTH     = 2;
  localparam logic [BOX_WIDTH-1:0] BOX_RESET = 31'd655360;

  // Edges are scaled to a magnitude of at most 2^30, so they fit 31 signed bits.
  localparam int EDGE_LIMIT_BITS   = 30;
  localparam int EDGE_WIDTH        = EDGE_LIMIT_BITS + 1;
  localparam int PROD_WIDTH        = 2 * EDGE_WIDTH;
  localparam int CROSS_WIDTH       = PROD_WIDTH + 1;
  localparam int CROSS_TARGET_BITS = 31;
  localparam int CLEN_WIDTH        = $clog2(CROSS_WIDTH + 1);
  localparam int CMAG_WIDTH        = 32;
  localparam int SQ_WIDTH          = 64;
  localparam int ROOT_WIDTH        = 32;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_BOX_X = 2'd0,
    REG_BOX_Y = 2'd1,
    REG_BOX_Z = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic en;
    logic valid;
  } ptun_ctl_t;

endpackage

>>> hdl/ptun_isqrt.sv
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per stage, with a sideband carried alongside.
// Depends on ptun_pkg.
module ptun_isqrt #(
  parameter int SIDE_WIDTH = 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ptun_pkg::ptun_ctl_t             ctl_in,
  input  logic [ptun_pkg::SQ_WIDTH-1:0]   in_sq,
  input  logic [SIDE_WIDTH-1:0]           in_side,
  output logic                            out_valid,
  output logic [ptun_pkg::ROOT_WIDTH-1:0] out_root,
  output logic [SIDE_WIDTH-1:0]           out_side
);
  import ptun_pkg::*;

  localparam int STEPS = ROOT_WIDTH;

  logic                  v_s    [STEPS+1];
  logic [SQ_WIDTH-1:0]   x_s    [STEPS+1];
  logic [SQ_WIDTH-1:0]   res_s  [STEPS+1];
  logic [SIDE_WIDTH-1:0] side_s [STEPS+1];

  assign v_s[0]    = ctl_in.valid;
  assign x_s[0]    = in_sq;
  assign res_s[0]  = '0;
  assign side_s[0] = in_side;

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam logic [SQ_WIDTH-1:0] BIT = SQ_WIDTH'(1) << (SQ_WIDTH - 2 - 2 * k);
    logic [SQ_WIDTH-1:0] trial;
    logic                take;

    // Restoring step: the trial subtrahend is the partial root plus this stage's bit.
    assign trial = res_s[k] + BIT;
    assign take  = (x_s[k] >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_s[k+1] <= 1'b0;
      end else if (ctl_in.en) begin
        v_s[k+1] <= v_s[k];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl_in.en) begin
        x_s[k+1]    <= take ? (x_s[k] - trial) : x_s[k];
        res_s[k+1]  <= take ? ((res_s[k] >> 1) + BIT) : (res_s[k] >> 1);
        side_s[k+1] <= side_s[k];
      end
    end
  end

  assign out_valid = v_s[STEPS];
  assign out_root  = res_s[STEPS][ROOT_WIDTH-1:0];
  assign out_side  = side_s[STEPS];

endmodule

>>> hdl/periodic_triangle_unit_normal.sv
`timescale 1ns / 1ps
// Top level of the periodic triangle unit normal: wrap, edge scaling, cross product,
// normalisation and output buffering. Depends on ptun_pkg and ptun_isqrt.
//
// From input accept to out_tvalid: ten front stages, one square-root stage per root bit, one
// divider stage per fraction bit, a rounding stage and the output register. Throughput: one item
// per cycle, set by the fully pipelined datapath; the pipeline only stalls when both the output
// register and the skid register are full. Reset (rst_n, synchronous, active low) clears all
// valid bits and the output buffering and loads every box length with 10.0; payload registers
// are not reset.
module periodic_triangle_unit_normal #(
  parameter int COORD_WIDTH   = ptun_pkg::COORD_WIDTH_DEF,
  parameter int OUT_FRAC_BITS = ptun_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // Input items.
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  // From bit 0: ref_x, ref_y, ref_z, second_x, second_y, second_z, third_x, third_y, third_z,
  // each COORD_WIDTH bits, then zero padding to whole bytes.
  input  logic [((9*COORD_WIDTH+7)/8)*8-1:0]      in_tdata,
  // Result items.
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  // From bit 0: normal_x, normal_y, normal_z, each OUT_FRAC_BITS+2 bits, then zero padding.
  output logic [((3*(OUT_FRAC_BITS+2)+7)/8)*8-1:0] out_tdata,
  // Bit 0: degenerate.
  output logic                                    out_tuser,
  // Configuration writes.
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [ptun_pkg::CFG_IDX_WIDTH-1:0]      cfg_index,
  input  logic [ptun_pkg::BOX_WIDTH-1:0]          cfg_data
);
  import ptun_pkg::*;

  localparam int NW     = OUT_FRAC_BITS + 2;
  localparam int OUT_W  = ((3 * NW + 7) / 8) * 8;
  localparam int DW     = COORD_WIDTH + 1;
  localparam int WW     = ((DW > 32) ? DW : 32) + 1;
  localparam int XW     = WW + 2;
  localparam int SHW    = $clog2(WW + 1);
  localparam int QW     = OUT_FRAC_BITS + 1;
  localparam int RW     = ROOT_WIDTH + 2;
  localparam int SIDE_W = 3 * CMAG_WIDTH + 3 + 1;
  localparam int OD_W   = 3 * NW + 1;

  // Position of the highest set bit, counted from one; zero for a zero word.
  function automatic logic [CLEN_WIDTH-1:0] msb_len(input logic [CROSS_WIDTH-1:0] v);
    logic [CLEN_WIDTH-1:0] n;
    n = '0;
    for (int i = 0; i < CROSS_WIDTH; i++) begin
      if (v[i]) n = CLEN_WIDTH'(i + 1);
    end
    return n;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Configuration: the three box lengths. Writes are always taken; unknown indices are
  // dropped.
  // ---------------------------------------------------------------------------------------
  logic [BOX_WIDTH-1:0] box_r [3];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r[0] <= BOX_RESET;
      box_r[1] <= BOX_RESET;
      box_r[2] <= BOX_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BOX_X: box_r[0] <= cfg_data;
        REG_BOX_Y: box_r[1] <= cfg_data;
        REG_BOX_Z: box_r[2] <= cfg_data;
        default:   ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------------------
  // Flow control. The whole pipeline moves together; it halts only while the skid register
  // holds an item, which means the output register is full.
  // ---------------------------------------------------------------------------------------
  logic      skid_v_r;
  logic      adv;
  ptun_ctl_t root_ctl;

  assign adv       = ~skid_v_r;
  assign in_tready = adv;

  logic in_fire;
  assign in_fire = in_tvalid & in_tready;

  // ---------------------------------------------------------------------------------------
  // Stage 1: edge vectors. Lanes 0..2 are edge one (second minus reference) along x, y, z,
  // lanes 3..5 are edge two (third minus reference).
  // ---------------------------------------------------------------------------------------
  logic                        s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r;
  logic                        s6_v_r, s7_v_r, s8_v_r, s9_v_r, s10_v_r;
  logic signed [DW-1:0]        d_r   [6];
  logic signed [WW-1:0]        w_r   [6];
  logic signed [WW-1:0]        w3_r  [6];
  logic [SHW-1:0]              esh_r [2];
  logic [WW-1:0]               wmag  [6];
  logic signed [EDGE_WIDTH-1:0] e_r  [6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      s5_v_r  <= 1'b0;
      s6_v_r  <= 1'b0;
      s7_v_r  <= 1'b0;
      s8_v_r  <= 1'b0;
      s9_v_r  <= 1'b0;
      s10_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r  <= in_fire;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      s4_v_r  <= s3_v_r;
      s5_v_r  <= s4_v_r;
      s6_v_r  <= s5_v_r;
      s7_v_r  <= s6_v_r;
      s8_v_r  <= s7_v_r;
      s9_v_r  <= s8_v_r;
      s10_v_r <= s9_v_r;
    end
  end

  for (genvar j = 0; j < 6; j++) begin : g_edge_lane
    localparam int A  = j % 3;
    localparam int HI = (j / 3 + 1) * 3 + A;

    logic signed [COORD_WIDTH-1:0] p_hi, p_lo;
    logic signed [XW-1:0]          dx, lx, t1, t2;
    logic signed [WW-1:0]          shifted;

    assign p_hi = in_tdata[HI*COORD_WIDTH +: COORD_WIDTH];
    assign p_lo = in_tdata[A*COORD_WIDTH +: COORD_WIDTH];

    // Stage 2 logic: minimum image wrap, applied once, compared exactly against half the box.
    assign dx = XW'(d_r[j]);
    assign lx = $signed({{(XW-BOX_WIDTH){1'b0}}, box_r[A]});
    assign t1 = ((dx <<< 1) > lx) ? (dx - lx) : dx;
    assign t2 = ((t1 <<< 1) < -lx) ? (t1 + lx) : t1;

    // Stage 3 logic: magnitude for the per-edge range search.
    assign wmag[j] = w_r[j][WW-1] ? WW'(-w_r[j]) : WW'(w_r[j]);

    // Stage 4 logic: arithmetic shift, which rounds toward minus infinity.
    assign shifted = w3_r[j] >>> esh_r[j/3];

    always_ff @(posedge clk) begin
      if (adv) begin
        d_r[j]  <= DW'(p_hi) - DW'(p_lo);
        w_r[j]  <= t2[WW-1:0];
        w3_r[j] <= w_r[j];
        e_r[j]  <= shifted[EDGE_WIDTH-1:0];
      end
    end
  end

  // Stage 3: the bit length of the OR of an edge's magnitudes equals that of their maximum.
  for (genvar e = 0; e < 2; e++) begin : g_edge_range
    logic [WW-1:0]         mor;
    logic [CLEN_WIDTH-1:0] len;

    assign mor = wmag[3*e] | wmag[3*e+1] | wmag[3*e+2];
    assign len = msb_len(CROSS_WIDTH'(mor));

    always_ff @(posedge clk) begin
      if (adv) begin
        esh_r[e] <= (len > CLEN_WIDTH'(EDGE_LIMIT_BITS)) ?
                    SHW'(len - CLEN_WIDTH'(EDGE_LIMIT_BITS)) : '0;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stages 5 and 6: cross product of the scaled edges, products registered before the
  // subtraction.
  // ---------------------------------------------------------------------------------------
  logic signed [PROD_WIDTH-1:0]  pa_r [3];
  logic signed [PROD_WIDTH-1:0]  pb_r [3];
  logic signed [CROSS_WIDTH-1:0] c_r  [3];

  for (genvar k = 0; k < 3; k++) begin : g_cross
    localparam int U = (k + 1) % 3;
    localparam int V = (k + 2) % 3;

    always_ff @(posedge clk) begin
      if (adv) begin
        pa_r[k] <= PROD_WIDTH'(e_r[U]) * PROD_WIDTH'(e_r[3+V]);
        pb_r[k] <= PROD_WIDTH'(e_r[V]) * PROD_WIDTH'(e_r[3+U]);
        c_r[k]  <= CROSS_WIDTH'(pa_r[k]) - CROSS_WIDTH'(pb_r[k]);
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage 7: range of the cross product. It is brought to a largest magnitude in [2^30, 2^31]
  // by a right shift (floor) or a left shift. An all-zero cross product is degenerate.
  // ---------------------------------------------------------------------------------------
  logic [CROSS_WIDTH-1:0]        cmag7 [3];
  logic [CROSS_WIDTH-1:0]        cor7;
  logic [CLEN_WIDTH-1:0]         clen7;
  logic signed [CROSS_WIDTH-1:0] c7_r  [3];
  logic                          right7_r, deg7_r;
  logic [CLEN_WIDTH-1:0]         csh7_r;

  for (genvar k = 0; k < 3; k++) begin : g_cmag
    assign cmag7[k] = c_r[k][CROSS_WIDTH-1] ? CROSS_WIDTH'(-c_r[k]) : CROSS_WIDTH'(c_r[k]);
  end

  assign cor7  = cmag7[0] | cmag7[1] | cmag7[2];
  assign clen7 = msb_len(cor7);

  always_ff @(posedge clk) begin
    if (adv) begin
      c7_r     <= c_r;
      right7_r <= (clen7 > CLEN_WIDTH'(CROSS_TARGET_BITS));
      csh7_r   <= (clen7 > CLEN_WIDTH'(CROSS_TARGET_BITS)) ?
                  (clen7 - CLEN_WIDTH'(CROSS_TARGET_BITS)) :
                  (CLEN_WIDTH'(CROSS_TARGET_BITS) - clen7);
      deg7_r   <= (clen7 == '0);
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stages 8 to 10: apply the shift, split into sign and magnitude, square and sum.
  // ---------------------------------------------------------------------------------------
  logic [CMAG_WIDTH-1:0] cm8_r  [3];
  logic                  neg8_r [3];
  logic                  deg8_r;
  logic [CMAG_WIDTH-1:0] cm9_r  [3];
  logic                  neg9_r [3];
  logic                  deg9_r;
  logic [SQ_WIDTH-1:0]   sqr9_r [3];
  logic [CMAG_WIDTH-1:0] cm10_r [3];
  logic                  neg10_r [3];
  logic                  deg10_r;
  logic [SQ_WIDTH-1:0]   sq10_r;

  for (genvar k = 0; k < 3; k++) begin : g_cscale
    logic signed [CROSS_WIDTH-1:0] cs;
    logic signed [CMAG_WIDTH:0]    cn;

    assign cs = right7_r ? (c7_r[k] >>> csh7_r) : (c7_r[k] <<< csh7_r);
    assign cn = cs[CMAG_WIDTH:0];

    always_ff @(posedge clk) begin
      if (adv) begin
        cm8_r[k]   <= cn[CMAG_WIDTH] ? CMAG_WIDTH'(-cn) : CMAG_WIDTH'(cn);
        neg8_r[k]  <= cn[CMAG_WIDTH];
        cm9_r[k]   <= cm8_r[k];
        neg9_r[k]  <= neg8_r[k];
        sqr9_r[k]  <= SQ_WIDTH'(cm8_r[k]) * SQ_WIDTH'(cm8_r[k]);
        cm10_r[k]  <= cm9_r[k];
        neg10_r[k] <= neg9_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      deg8_r  <= deg7_r;
      deg9_r  <= deg8_r;
      deg10_r <= deg9_r;
      sq10_r  <= sqr9_r[0] + sqr9_r[1] + sqr9_r[2];
    end
  end

  // ---------------------------------------------------------------------------------------
  // Square root of the squared norm; the signed magnitudes and the degenerate flag ride along.
  // ---------------------------------------------------------------------------------------
  logic [SIDE_W-1:0]     side_in, side_out;
  logic                  rt_v;
  logic [ROOT_WIDTH-1:0] rt_root;

  assign side_in  = {deg10_r, neg10_r[2], neg10_r[1], neg10_r[0],
                     cm10_r[2], cm10_r[1], cm10_r[0]};
  assign root_ctl = '{en: adv, valid: s10_v_r};

  ptun_isqrt #(
    .SIDE_WIDTH(SIDE_W)
  ) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_in   (root_ctl),
    .in_sq    (sq10_r),
    .in_side  (side_in),
    .out_valid(rt_v),
    .out_root (rt_root),
    .out_side (side_out)
  );

  // ---------------------------------------------------------------------------------------
  // Division: three restoring dividers, one quotient bit per stage, computing
  // |c| * 2^OUT_FRAC_BITS / r. Since |c| never exceeds r the quotient needs one integer bit.
  // ---------------------------------------------------------------------------------------
  logic                  dv_s   [OUT_FRAC_BITS+1];
  logic [ROOT_WIDTH-1:0] r_s    [OUT_FRAC_BITS+1];
  logic [2:0]            neg_s  [OUT_FRAC_BITS+1];
  logic                  deg_s  [OUT_FRAC_BITS+1];
  logic [RW-1:0]         rem_s  [OUT_FRAC_BITS+1][3];
  logic [QW-1:0]         q_s    [OUT_FRAC_BITS+1][3];

  assign dv_s[0]  = rt_v;
  assign r_s[0]   = rt_root;
  assign neg_s[0] = side_out[3*CMAG_WIDTH +: 3];
  assign deg_s[0] = side_out[SIDE_W-1];

  for (genvar k = 0; k < 3; k++) begin : g_div_init
    assign rem_s[0][k] = RW'(side_out[k*CMAG_WIDTH +: CMAG_WIDTH]);
    assign q_s[0][k]   = '0;
  end

  for (genvar j = 0; j < OUT_FRAC_BITS; j++) begin : g_div_stage
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_s[j+1] <= 1'b0;
      end else if (adv) begin
        dv_s[j+1] <= dv_s[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        r_s[j+1]   <= r_s[j];
        neg_s[j+1] <= neg_s[j];
        deg_s[j+1] <= deg_s[j];
      end
    end

    for (genvar k = 0; k < 3; k++) begin : g_lane
      logic [RW-1:0] rem2;
      logic          take;

      assign rem2 = {rem_s[j][k][RW-2:0], 1'b0};
      assign take = (rem2 >= RW'(r_s[j]));

      always_ff @(posedge clk) begin
        if (adv) begin
          rem_s[j+1][k] <= take ? (rem2 - RW'(r_s[j])) : rem2;
          q_s[j+1][k]   <= {q_s[j][k][QW-2:0], take};
        end
      end
    end
  end

  // Final stage: round half up on the magnitude, restore the sign, clear degenerate items.
  localparam int FB = OUT_FRAC_BITS;

  logic                 fin_v_r;
  logic [OD_W-1:0]      fin_d;
  logic signed [NW-1:0] n_r [3];
  logic                 fdeg_r;

  for (genvar k = 0; k < 3; k++) begin : g_round
    logic [QW-1:0]        qr;
    logic signed [NW-1:0] ns;

    assign qr = q_s[FB][k] + QW'({rem_s[FB][k][RW-2:0], 1'b0} >= RW'(r_s[FB]));
    assign ns = neg_s[FB][k] ? -$signed(NW'(qr)) : $signed(NW'(qr));

    always_ff @(posedge clk) begin
      if (adv) begin
        n_r[k] <= deg_s[FB] ? '0 : ns;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_v_r <= 1'b0;
    end else if (adv) begin
      fin_v_r <= dv_s[FB];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fdeg_r <= deg_s[FB];
    end
  end

  assign fin_d = {fdeg_r, n_r[2], n_r[1], n_r[0]};

  // ---------------------------------------------------------------------------------------
  // Output register with a skid register behind it, so that a finished item that arrives while
  // the output register is full and not drained is caught there before the pipeline halts.
  // ---------------------------------------------------------------------------------------
  logic            out_v_r, out_v_nxt;
  logic [OD_W-1:0] out_d_r, out_d_nxt;
  logic            skid_v_nxt;
  logic [OD_W-1:0] skid_d_r, skid_d_nxt;
  logic            out_fire;

  assign out_fire = out_v_r & out_tready;

  always_comb begin
    out_v_nxt  = out_v_r;
    out_d_nxt  = out_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    if (adv && fin_v_r) begin
      if (!out_v_r || out_fire) begin
        out_v_nxt = 1'b1;
        out_d_nxt = fin_d;
      end else begin
        skid_v_nxt = 1'b1;
        skid_d_nxt = fin_d;
      end
    end else if (out_fire) begin
      if (skid_v_r) begin
        out_d_nxt  = skid_d_r;
        skid_v_nxt = 1'b0;
      end else begin
        out_v_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = OUT_W'(out_d_r[3*NW-1:0]);
  assign out_tuser  = out_d_r[OD_W-1];

  // ---------------------------------------------------------------------------------------
  // Checks.
  // ---------------------------------------------------------------------------------------
  localparam logic signed [NW-1:0] UNIT = NW'(1) <<< OUT_FRAC_BITS;

  logic signed [NW-1:0] chk_nx;
  assign chk_nx = out_d_r[NW-1:0];

  // The skid register only fills behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid register holds an item while the output register is empty");

  // A degenerate triangle gives an all-zero normal.
  a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == '0))
    else $error("degenerate item with a non-zero normal");

  // The x component of a non-degenerate normal is at most one in magnitude.
  a_unit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (chk_nx <= UNIT && chk_nx >= -UNIT))
    else $error("normal x component exceeds one");

  // While the pipeline is halted the valid bit of its last stage must not change.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(fin_v_r))
    else $error("last pipeline stage changed during a stall");

endmodule
